[design/ovn_pkg.sv]
`default_nettype none
package ovn_pkg;

    localparam int GRID_SIZE  = 64;
    localparam int GRID_LG    = $clog2(GRID_SIZE);
    localparam int COORD_W    = GRID_LG;
    localparam int ADDR_W     = 2 * COORD_W;
    localparam int CELLS      = GRID_SIZE * GRID_SIZE;
    localparam int SEED_W     = 16;
    localparam int NOISE_W    = 16;
    localparam int FRAC_W     = 16;
    localparam int OCT_W      = 3;
    localparam int BIAS_W     = 16;
    localparam int BIAS_FRAC  = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam int W_W        = 48;
    localparam int ACC_W      = 64;
    localparam int DVD_W      = 64;
    localparam int CNT_W      = 7;
    localparam int OPA_W      = FRAC_W + 1;
    localparam int OPB_W      = 16;
    localparam int PROD_W     = OPA_W + OPB_W;
    localparam int NUM_WT     = GRID_LG;
    localparam int WDIV_LEN   = W_W + BIAS_FRAC;

    typedef logic [COORD_W-1:0] t_coord;
    typedef logic [OCT_W-1:0]   t_oct;
    typedef logic [SEED_W-1:0]  t_seed;
    typedef logic [W_W-1:0]     t_wt;
    typedef logic [CNT_W-1:0]   t_cnt;
    typedef logic [BIAS_W-1:0]  t_bias;

    localparam logic [CFG_IDX_W-1:0] REG_OCTAVE_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_BIAS         = 1'b1;

    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    localparam t_oct             OCT_RST   = 3'd1;
    localparam t_bias            BIAS_RST  = 16'd512;
    localparam t_bias            BIAS_MIN  = 16'd64;
    localparam t_oct             GRID_LG_O = t_oct'(GRID_LG);
    localparam logic [OPA_W-1:0] ONE_Q16   = 17'h1_0000;
    localparam t_wt              W_INIT    = 48'h0001_0000_0000;

    typedef struct packed {
        logic                 start;
        logic [W_W-1:0]       rem;
        logic [DVD_W-1:0]     dvd;
        logic [W_W-1:0]       dsr;
        logic [CNT_W-1:0]     len;
    } t_div_req;

    typedef struct packed {
        logic                 busy;
        logic                 done;
        logic [W_W-1:0]       quo;
    } t_div_rsp;

endpackage
`default_nettype wire

[design/ovn_in_if.sv]
`default_nettype none
interface ovn_in_if;
    logic                           valid;
    logic                           ready;
    logic                           func;
    logic [ovn_pkg::COORD_W-1:0]    x;
    logic [ovn_pkg::COORD_W-1:0]    y;
    logic [ovn_pkg::SEED_W-1:0]     seed_value;

    modport source (output valid, output func, output x, output y, output seed_value,
                    input ready);
    modport sink   (input valid, input func, input x, input y, input seed_value,
                    output ready);
endinterface
`default_nettype wire

[design/ovn_out_if.sv]
`default_nettype none
interface ovn_out_if;
    logic                           valid;
    logic                           ready;
    logic [ovn_pkg::NOISE_W-1:0]    noise;

    modport source (output valid, output noise, input ready);
    modport sink   (input valid, input noise, output ready);
endinterface
`default_nettype wire

[design/ovn_cfg_if.sv]
`default_nettype none
interface ovn_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [ovn_pkg::CFG_IDX_W-1:0]      index;
    logic [ovn_pkg::CFG_DATA_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

[design/ovn_div.sv]
`default_nettype none
module ovn_div (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire ovn_pkg::t_div_req  i_req,
    output ovn_pkg::t_div_rsp       o_rsp
);

    logic                           r_busy;
    logic                           r_done;
    ovn_pkg::t_cnt                  r_cnt;
    logic [ovn_pkg::W_W-1:0]        r_rem;
    logic [ovn_pkg::W_W-1:0]        r_dsr;
    logic [ovn_pkg::W_W-1:0]        r_q;
    logic [ovn_pkg::DVD_W-1:0]      r_dvd;

    logic [ovn_pkg::W_W:0]          trial;
    logic [ovn_pkg::W_W:0]          diff;
    logic                           take;
    logic [ovn_pkg::W_W-1:0]        n_rem;

    // one quotient bit per cycle, restoring
    assign trial = {r_rem, r_dvd[ovn_pkg::DVD_W-1]};
    assign diff  = trial - {1'b0, r_dsr};
    assign take  = (trial >= {1'b0, r_dsr});
    assign n_rem = take ? diff[ovn_pkg::W_W-1:0] : trial[ovn_pkg::W_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.len;
            end else if (r_busy) begin
                r_cnt <= r_cnt - ovn_pkg::t_cnt'(1);
                if (r_cnt == ovn_pkg::t_cnt'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= i_req.rem;
            r_dvd <= i_req.dvd;
            r_dsr <= i_req.dsr;
            r_q   <= '0;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_dvd <= {r_dvd[ovn_pkg::DVD_W-2:0], 1'b0};
            r_q   <= {r_q[ovn_pkg::W_W-2:0], take};
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_q;

endmodule
`default_nettype wire

[design/octave_value_noise_2d_core.sv]
// octave value noise over a 64 x 64 grid of q0.16 seeds
//
// i_in carries requests: func load writes seed_value at (x,y) and gives no
// result; func query returns the octave value noise at (x,y) on o_res.
// i_cfg writes octave_count (index 0) and bias (index 1); it is always ready
// and is meant to be written only while the block is idle.
//
// loads may follow back to back. in a query each octave reads four seeds from
// the seed memory and runs eleven steps through one shared 17x16 multiplier,
// and the closing normalize runs 16 steps of the serial divider. the octave
// weights are kept after the first query that needs them; after a bias write
// each weight is rebuilt once by the serial divider. i_in is not ready while
// a query is in flight.
//
// the result sits in an output register; a stalled receiver only holds the
// next query at its end, loads are still taken while the block is idle.
// reset returns octave_count to 1 and bias to 2.0 and empties the output;
// the seed memory is not cleared and must be loaded before it is queried.
`default_nettype none
module octave_value_noise_2d_core (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    ovn_in_if.sink              i_in,
    ovn_cfg_if.sink             i_cfg,
    ovn_out_if.source           o_res
);

    localparam int STEP_W = 4;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_READ = 3'd1;
    localparam logic [2:0] S_LERP = 3'd2;
    localparam logic [2:0] S_WDIV = 3'd3;
    localparam logic [2:0] S_FDIV = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0]                         r_state;
    logic [STEP_W-1:0]                  r_step;
    ovn_pkg::t_oct                      r_oct;
    ovn_pkg::t_oct                      r_oct_cnt;
    ovn_pkg::t_bias                     r_bias;
    ovn_pkg::t_oct                      r_wt_n;
    ovn_pkg::t_wt                       r_wt [ovn_pkg::NUM_WT];
    ovn_pkg::t_coord                    r_x;
    ovn_pkg::t_coord                    r_y;
    ovn_pkg::t_wt                       r_w;
    ovn_pkg::t_wt                       r_wsum;
    logic [ovn_pkg::ACC_W-1:0]          r_acc;
    ovn_pkg::t_seed                     r_seed_mem [ovn_pkg::CELLS];
    ovn_pkg::t_seed                     r_rd;
    ovn_pkg::t_seed                     r_seed [4];
    logic [ovn_pkg::PROD_W-1:0]         r_prod;
    logic [ovn_pkg::PROD_W-1:0]         r_lsum;
    ovn_pkg::t_seed                     r_top;
    logic [ovn_pkg::NOISE_W-1:0]        r_res;
    logic                               r_ovld;
    logic [ovn_pkg::NOISE_W-1:0]        r_noise;

    logic                               in_acc;
    logic                               cfg_acc;
    logic                               out_free;
    ovn_pkg::t_oct                      oct_eff;
    logic                               oct_last;
    ovn_pkg::t_bias                     bdiv;
    ovn_pkg::t_oct                      lp;
    ovn_pkg::t_coord                    mask;
    logic [ovn_pkg::COORD_W:0]          pitch;
    ovn_pkg::t_coord                    x1;
    ovn_pkg::t_coord                    y1;
    ovn_pkg::t_coord                    x2;
    ovn_pkg::t_coord                    y2;
    logic [ovn_pkg::COORD_W+ovn_pkg::FRAC_W-1:0] fx_wide;
    logic [ovn_pkg::COORD_W+ovn_pkg::FRAC_W-1:0] fy_wide;
    logic [ovn_pkg::OPA_W-1:0]          fx;
    logic [ovn_pkg::OPA_W-1:0]          fy;
    logic [ovn_pkg::OPA_W-1:0]          one_m_fx;
    logic [ovn_pkg::OPA_W-1:0]          one_m_fy;
    ovn_pkg::t_seed                     smp;
    logic [ovn_pkg::ADDR_W-1:0]         rd_addr;
    logic [ovn_pkg::OPA_W-1:0]          op_a;
    logic [ovn_pkg::OPB_W-1:0]          op_b;
    ovn_pkg::t_div_req                  div_req;
    ovn_pkg::t_div_rsp                  div_rsp;

    assign in_acc   = i_in.valid && i_in.ready;
    assign cfg_acc  = i_cfg.valid && i_cfg.ready;
    assign out_free = !r_ovld || o_res.ready;

    assign oct_eff  = (r_oct_cnt == '0) ? ovn_pkg::t_oct'(1) : r_oct_cnt;
    assign oct_last = (r_oct == oct_eff - ovn_pkg::t_oct'(1));
    assign bdiv     = (r_bias < ovn_pkg::BIAS_MIN) ? ovn_pkg::BIAS_MIN : r_bias;

    // cell corners and blend fractions of the current octave
    assign lp       = ovn_pkg::GRID_LG_O - r_oct;
    assign mask     = ~({ovn_pkg::COORD_W{1'b1}} << lp);
    assign pitch    = {{ovn_pkg::COORD_W{1'b0}}, 1'b1} << lp;
    assign x1       = r_x & ~mask;
    assign y1       = r_y & ~mask;
    assign x2       = ovn_pkg::t_coord'({1'b0, x1} + pitch);
    assign y2       = ovn_pkg::t_coord'({1'b0, y1} + pitch);
    assign fx_wide  = {r_x & mask, {ovn_pkg::FRAC_W{1'b0}}} >> lp;
    assign fy_wide  = {r_y & mask, {ovn_pkg::FRAC_W{1'b0}}} >> lp;
    assign fx       = {1'b0, fx_wide[ovn_pkg::FRAC_W-1:0]};
    assign fy       = {1'b0, fy_wide[ovn_pkg::FRAC_W-1:0]};
    assign one_m_fx = ovn_pkg::ONE_Q16 - fx;
    assign one_m_fy = ovn_pkg::ONE_Q16 - fy;
    assign smp      = r_lsum[2*ovn_pkg::FRAC_W-1:ovn_pkg::FRAC_W];

    always_comb begin
        unique case (r_step[1:0])
            2'd0:    rd_addr = {y1, x1};
            2'd1:    rd_addr = {y1, x2};
            2'd2:    rd_addr = {y2, x1};
            default: rd_addr = {y2, x2};
        endcase
    end

    // seed memory
    always_ff @(posedge i_clk) begin
        if (in_acc && i_in.func == ovn_pkg::FUNC_LOAD) begin
            r_seed_mem[{i_in.y, i_in.x}] <= i_in.seed_value;
        end
        r_rd <= r_seed_mem[rd_addr];
    end

    // shared multiplier operands
    always_comb begin
        op_a = '0;
        op_b = '0;
        if (r_state == S_LERP) begin
            unique case (r_step)
                4'd0: begin
                    op_a = one_m_fx;
                    op_b = r_seed[0];
                end
                4'd1: begin
                    op_a = fx;
                    op_b = r_seed[1];
                end
                4'd2: begin
                    op_a = one_m_fx;
                    op_b = r_seed[2];
                end
                4'd3: begin
                    op_a = fx;
                    op_b = r_seed[3];
                end
                4'd4: begin
                    op_a = one_m_fy;
                    op_b = r_top;
                end
                4'd5: begin
                    op_a = fy;
                    op_b = smp;
                end
                4'd7: begin
                    op_a = {1'b0, smp};
                    op_b = r_w[15:0];
                end
                4'd8: begin
                    op_a = {1'b0, smp};
                    op_b = r_w[31:16];
                end
                4'd9: begin
                    op_a = {1'b0, smp};
                    op_b = r_w[47:32];
                end
                default: begin
                    op_a = '0;
                    op_b = '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= op_a * op_b;
    end

    // serial divider requests: next weight or final normalize
    always_comb begin
        div_req.start = (r_state == S_WDIV || r_state == S_FDIV) && r_step == '0;
        if (r_state == S_WDIV) begin
            div_req.rem = '0;
            div_req.dvd = {r_w, {(ovn_pkg::DVD_W-ovn_pkg::W_W){1'b0}}};
            div_req.dsr = ovn_pkg::t_wt'(bdiv);
            div_req.len = ovn_pkg::t_cnt'(ovn_pkg::WDIV_LEN);
        end else begin
            div_req.rem = r_acc[ovn_pkg::ACC_W-1:ovn_pkg::FRAC_W];
            div_req.dvd = {r_acc[ovn_pkg::FRAC_W-1:0],
                           {(ovn_pkg::DVD_W-ovn_pkg::FRAC_W){1'b0}}};
            div_req.dsr = r_wsum;
            div_req.len = ovn_pkg::t_cnt'(ovn_pkg::FRAC_W);
        end
    end

    ovn_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_step    <= '0;
            r_oct     <= '0;
            r_oct_cnt <= ovn_pkg::OCT_RST;
            r_bias    <= ovn_pkg::BIAS_RST;
            r_wt_n    <= '0;
            r_ovld    <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc && i_in.func == ovn_pkg::FUNC_QUERY) begin
                        r_state <= S_READ;
                        r_step  <= '0;
                        r_oct   <= '0;
                    end
                end
                S_READ: begin
                    if (r_step == 4'd4) begin
                        r_state <= S_LERP;
                        r_step  <= '0;
                    end else begin
                        r_step <= r_step + 4'd1;
                    end
                end
                S_LERP: begin
                    if (r_step == 4'd10) begin
                        r_step <= '0;
                        priority if (oct_last) begin
                            r_state <= S_FDIV;
                        end else if (r_oct < r_wt_n) begin
                            r_oct   <= r_oct + ovn_pkg::t_oct'(1);
                            r_state <= S_READ;
                        end else begin
                            r_state <= S_WDIV;
                        end
                    end else begin
                        r_step <= r_step + 4'd1;
                    end
                end
                S_WDIV: begin
                    if (r_step == '0) begin
                        r_step <= 4'd1;
                    end else if (div_rsp.done) begin
                        r_wt_n  <= r_oct + ovn_pkg::t_oct'(1);
                        r_oct   <= r_oct + ovn_pkg::t_oct'(1);
                        r_step  <= '0;
                        r_state <= S_READ;
                    end
                end
                S_FDIV: begin
                    if (r_step == '0) begin
                        r_step <= 4'd1;
                    end else if (div_rsp.done) begin
                        r_step  <= '0;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            if (r_state == S_OUT && out_free) begin
                r_ovld <= 1'b1;
            end else if (o_res.ready) begin
                r_ovld <= 1'b0;
            end

            if (cfg_acc) begin
                unique case (i_cfg.index)
                    ovn_pkg::REG_OCTAVE_COUNT: begin
                        r_oct_cnt <= i_cfg.data[ovn_pkg::OCT_W-1:0];
                    end
                    ovn_pkg::REG_BIAS: begin
                        r_bias <= i_cfg.data[ovn_pkg::BIAS_W-1:0];
                        r_wt_n <= '0;
                    end
                endcase
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_x    <= i_in.x;
            r_y    <= i_in.y;
            r_acc  <= '0;
            r_wsum <= '0;
            r_w    <= ovn_pkg::W_INIT;
        end

        if (r_state == S_READ && r_step != '0) begin
            r_seed[r_step[1:0] - 2'd1] <= r_rd;
        end

        if (r_state == S_LERP) begin
            if (r_step == 4'd1 || r_step == 4'd3 || r_step == 4'd5) begin
                r_lsum <= r_prod;
            end
            if (r_step == 4'd2 || r_step == 4'd4 || r_step == 4'd6) begin
                r_lsum <= r_lsum + r_prod;
            end
            if (r_step == 4'd3) begin
                r_top <= smp;
            end
            if (r_step == 4'd8) begin
                r_acc <= r_acc + ovn_pkg::ACC_W'(r_prod);
            end
            if (r_step == 4'd9) begin
                r_acc <= r_acc + (ovn_pkg::ACC_W'(r_prod) << ovn_pkg::FRAC_W);
            end
            if (r_step == 4'd10) begin
                r_acc  <= r_acc + (ovn_pkg::ACC_W'(r_prod) << (2 * ovn_pkg::FRAC_W));
                r_wsum <= r_wsum + r_w;
                if (!oct_last && r_oct < r_wt_n) begin
                    r_w <= r_wt[r_oct];
                end
            end
        end

        if (r_state == S_WDIV && r_step != '0 && div_rsp.done) begin
            r_w         <= div_rsp.quo;
            r_wt[r_oct] <= div_rsp.quo;
        end

        if (r_state == S_FDIV && r_step != '0 && div_rsp.done) begin
            r_res <= div_rsp.quo[ovn_pkg::NOISE_W-1:0];
        end

        if (r_state == S_OUT && out_free) begin
            r_noise <= r_res;
        end
    end

    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign o_res.valid = r_ovld;
    assign o_res.noise = r_noise;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && r_ovld && !o_res.ready) |=> (r_state == S_OUT))
        else $error("finished query left while output register still full");

    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");

    a_oct_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> (r_oct < oct_eff))
        else $error("octave index beyond octave count");

endmodule
`default_nettype wire

[tb/ovn_noise_checker.sv]
module ovn_noise_checker (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    ovn_in_if           i_in,
    ovn_cfg_if          i_cfg,
    ovn_out_if          i_res,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked
);
    import ovn_pkg::*;

    t_seed                  seed_mem [CELLS];
    t_oct                   octaves;
    t_bias                  bias_q88;
    logic [NOISE_W-1:0]     noise_expected [$];
    logic [NOISE_W-1:0]     want;

    function automatic logic [63:0] seed_at(input int unsigned col, input int unsigned row);
        return 64'(seed_mem[row * GRID_SIZE + col]);
    endfunction

    function automatic logic [63:0] blend_q16(input logic [63:0] a, input logic [63:0] b,
                                              input logic [63:0] f);
        return ((64'd65536 - f) * a + f * b) >> 16;
    endfunction

    function automatic logic [NOISE_W-1:0] octave_noise_at(input t_coord px, input t_coord py);
        int unsigned    n_oct, o, pitch, x1, y1, x2, y2;
        logic [63:0]    bdiv, w, wsum, acc, fx, fy, top, bot, s;
        n_oct = (octaves == 0) ? 1 : octaves;
        bdiv  = (bias_q88 < BIAS_MIN) ? 64'(BIAS_MIN) : 64'(bias_q88);
        w     = 64'd1 << 32;
        wsum  = '0;
        acc   = '0;
        for (o = 0; o < n_oct; o++) begin
            pitch = GRID_SIZE >> o;
            if (pitch == 0) begin
                pitch = 1;
            end
            x1  = (px / pitch) * pitch;
            y1  = (py / pitch) * pitch;
            x2  = (x1 + pitch) % GRID_SIZE;
            y2  = (y1 + pitch) % GRID_SIZE;
            fx  = (64'(px - x1) << 16) / pitch;
            fy  = (64'(py - y1) << 16) / pitch;
            top = blend_q16(seed_at(x1, y1), seed_at(x2, y1), fx);
            bot = blend_q16(seed_at(x1, y2), seed_at(x2, y2), fx);
            s   = blend_q16(top, bot, fy);
            wsum += w;
            acc  += s * w;
            w     = (w << 8) / bdiv;
        end
        acc = acc / wsum;
        return (acc > 64'd65535) ? 16'hFFFF : acc[NOISE_W-1:0];
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            octaves  = OCT_RST;
            bias_q88 = BIAS_RST;
            noise_expected.delete();
            o_fail_count = 0;
            o_checked    = 0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                if (i_cfg.index == REG_OCTAVE_COUNT) begin
                    octaves = i_cfg.data[OCT_W-1:0];
                end else if (i_cfg.index == REG_BIAS) begin
                    bias_q88 = i_cfg.data[BIAS_W-1:0];
                end
            end
            if (i_in.valid && i_in.ready) begin
                if (i_in.func == FUNC_LOAD) begin
                    seed_mem[i_in.y * GRID_SIZE + i_in.x] = i_in.seed_value;
                end else begin
                    noise_expected.insert(noise_expected.size(),
                                          octave_noise_at(i_in.x, i_in.y));
                end
            end
            if (i_res.valid && i_res.ready) begin
                if (noise_expected.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10) begin
                        $display("noise result %h with no query waiting", i_res.noise);
                    end
                end else begin
                    want = noise_expected.pop_front();
                    o_checked++;
                    if (i_res.noise !== want) begin
                        o_fail_count++;
                        if (o_fail_count <= 10) begin
                            $display("noise mismatch: expected %h, got %h", want, i_res.noise);
                        end
                    end
                end
            end
        end
        o_pending = noise_expected.size();
    end

endmodule

[tb/tb_octave_value_noise_2d_core.sv]
module tb_octave_value_noise_2d_core;
    import ovn_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = 16;
    localparam int TAIL_CYCLES    = 200;
    localparam int MAX_OCTAVES    = 7;

    logic   i_clk = 1'b0;
    logic   i_rst_n;

    ovn_in_if   in_if ();
    ovn_cfg_if  cfg_if ();
    ovn_out_if  res_if ();

    int     fail_count;
    int     pending;
    int     checked;
    int     send_idle_pct;
    int     recv_idle_pct;
    int     items_sent;
    int     loads_sent;
    int     queries_sent;
    int     settings_used;
    int     idle_run;
    bit     seed_loaded [CELLS];

    octave_value_noise_2d_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .i_cfg   (cfg_if),
        .o_res   (res_if)
    );

    ovn_noise_checker u_noise_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_if),
        .i_cfg        (cfg_if),
        .i_res        (res_if),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    always #5 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (res_if.valid && res_if.ready)
                || (cfg_if.valid && cfg_if.ready)) begin
            idle_run <= 0;
        end else if (idle_run + 1 >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("tb_octave_value_noise_2d_core NOT OK");
            $finish;
        end else begin
            idle_run <= idle_run + 1;
        end
    end

    function automatic t_seed rand_seed();
        int pick;
        pick = $urandom_range(7);
        if (pick == 0) begin
            return '0;
        end else if (pick == 1) begin
            return '1;
        end
        return t_seed'($urandom);
    endfunction

    function automatic t_coord rand_coord();
        int pick;
        pick = $urandom_range(7);
        if (pick == 0) begin
            return '0;
        end else if (pick == 1) begin
            return t_coord'(GRID_SIZE - 1);
        end
        return t_coord'($urandom);
    endfunction

    task automatic send_request(input logic f, input t_coord rx, input t_coord ry,
                                input t_seed sv);
        if ($urandom_range(99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
            while ($urandom_range(99) < send_idle_pct) @(negedge i_clk);
        end
        in_if.valid      <= 1'b1;
        in_if.func       <= f;
        in_if.x          <= rx;
        in_if.y          <= ry;
        in_if.seed_value <= sv;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        @(negedge i_clk);
        items_sent++;
    endtask

    task automatic load_seed(input t_coord lx, input t_coord ly, input t_seed sv);
        send_request(FUNC_LOAD, lx, ly, sv);
        seed_loaded[ly * GRID_SIZE + lx] = 1'b1;
        loads_sent++;
    endtask

    // every corner that any octave may read gets a seed before the query goes out
    task automatic query_noise(input t_coord qx, input t_coord qy);
        int unsigned    o, i, j, pitch;
        int unsigned    cx [2];
        int unsigned    cy [2];
        for (o = 0; o < MAX_OCTAVES; o++) begin
            pitch = GRID_SIZE >> o;
            cx[0] = (qx / pitch) * pitch;
            cy[0] = (qy / pitch) * pitch;
            cx[1] = (cx[0] + pitch) % GRID_SIZE;
            cy[1] = (cy[0] + pitch) % GRID_SIZE;
            for (i = 0; i < 2; i++) begin
                for (j = 0; j < 2; j++) begin
                    if (!seed_loaded[cy[j] * GRID_SIZE + cx[i]]) begin
                        load_seed(t_coord'(cx[i]), t_coord'(cy[j]), rand_seed());
                    end
                end
            end
        end
        send_request(FUNC_QUERY, qx, qy, t_seed'($urandom));
        queries_sent++;
    endtask

    task automatic settle();
        in_if.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_config(input t_oct oct, input t_bias b);
        settle();
        cfg_if.valid <= 1'b1;
        cfg_if.index <= REG_OCTAVE_COUNT;
        cfg_if.data  <= CFG_DATA_W'(oct);
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_if.index <= REG_BIAS;
        cfg_if.data  <= b;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
        settings_used++;
    endtask

    task automatic run_random(input int n, input bit with_pause);
        int target, half;
        target = items_sent + n;
        half   = items_sent + n / 2;
        while (items_sent < target) begin
            if (with_pause && items_sent >= half) begin
                settle();
                with_pause = 1'b0;
            end
            if ($urandom_range(3) == 0) begin
                load_seed(rand_coord(), rand_coord(), rand_seed());
            end else begin
                query_noise(rand_coord(), rand_coord());
            end
        end
    endtask

    initial begin
        i_rst_n             = 1'b0;
        in_if.valid         = 1'b0;
        in_if.func          = FUNC_LOAD;
        in_if.x             = '0;
        in_if.y             = '0;
        in_if.seed_value    = '0;
        cfg_if.valid        = 1'b0;
        cfg_if.index        = REG_OCTAVE_COUNT;
        cfg_if.data         = '0;
        res_if.ready        = 1'b0;
        send_idle_pct       = 31;
        recv_idle_pct       = 72;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset setting: a single octave folds every corner onto the origin
        load_seed(6'd0, 6'd0, '1);
        query_noise(6'd0, 6'd0);
        query_noise(6'd63, 6'd63);
        load_seed(6'd63, 6'd63, '0);
        set_config(3'd7, BIAS_MIN);
        query_noise(6'd63, 6'd63);
        query_noise(6'd0, 6'd0);
        query_noise(6'd31, 6'd33);
        // zero octave count and a bias under the floor
        set_config(3'd0, 16'd0);
        query_noise(6'd17, 6'd45);
        set_config(3'd7, 16'd63);
        query_noise(6'd63, 6'd0);
        set_config(3'd3, 16'hFFFF);
        query_noise(6'd5, 6'd60);
        query_noise(6'd62, 6'd1);

        set_config(t_oct'($urandom_range(1, 7)), t_bias'($urandom));
        run_random(100, 1'b0);
        set_config(3'd7, BIAS_RST);
        run_random(100, 1'b0);

        send_idle_pct = 72;
        recv_idle_pct = 31;
        set_config(3'd1, 16'hFFFF);
        run_random(100, 1'b1);
        set_config(t_oct'($urandom_range(7)), t_bias'($urandom));
        run_random(100, 1'b0);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_config(3'd6, 16'd256);
        run_random(100, 1'b0);
        set_config(3'd7, BIAS_MIN);
        run_random(100, 1'b0);

        settle();
        repeat (TAIL_CYCLES) @(negedge i_clk);

        $display("drove %0d seed loads and %0d noise queries over %0d register settings",
                 loads_sent, queries_sent, settings_used);
        $display("compared %0d noise results under three flow-control mixes", checked);
        if (fail_count == 0 && pending == 0) begin
            $display("tb_octave_value_noise_2d_core OK");
        end else begin
            $display("tb_octave_value_noise_2d_core NOT OK");
        end
        $finish;
    end

endmodule

[sim.f]
design/ovn_pkg.sv
design/ovn_in_if.sv
design/ovn_out_if.sv
design/ovn_cfg_if.sv
design/ovn_div.sv
design/octave_value_noise_2d_core.sv
tb/ovn_noise_checker.sv
tb/tb_octave_value_noise_2d_core.sv
